// File: rtl/core/p2t_pkg.sv
// Shared types, constants and codes for the pixel-to-tile lookup block.
package p2t_pkg;

    localparam int GRID       = 8;
    localparam int TILES      = GRID * GRID;
    localparam int IDX_BITS   = $clog2(TILES);
    localparam int GRID_BITS  = $clog2(GRID);
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int NORM_BITS  = FRAC_BITS + 1;
    localparam int CNT_BITS   = $clog2(NORM_BITS + 1);

    // Item kinds carried on the input tuser bit
    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    // One tile rectangle as stored in the table, origin x in the lowest bits
    typedef struct packed {
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } tile_entry_t;

    localparam int ENTRY_BITS = $bits(tile_entry_t);

    // Input payload, first field in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [1:0]            pad;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] rect_height;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_x;
        logic [GRID_BITS-1:0]  tile_col;
        logic [GRID_BITS-1:0]  tile_row;
    } in_item_t;

    localparam int IN_BITS = $bits(in_item_t);

    // Result payload, first field in the lowest bits
    typedef struct packed {
        logic [NORM_BITS-1:0] norm_y;
        logic [NORM_BITS-1:0] norm_x;
        logic [IDX_BITS-1:0]  tile_number;
    } out_item_t;

    localparam int OUT_BITS = $bits(out_item_t);

endpackage

// File: rtl/core/p2t_ram.sv
// Generic single-write, single-read RAM with registered read data.
module p2t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/p2t_div.sv
// Restoring divider: offset * 2^FRAC_BITS / size, one quotient bit per cycle.
module p2t_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [p2t_pkg::COORD_BITS-1:0]      off,
    input  logic [p2t_pkg::COORD_BITS-1:0]      size,
    output logic                                done,
    output logic [p2t_pkg::NORM_BITS-1:0]       quo
);

    logic [p2t_pkg::COORD_BITS:0]     rem_reg, rem_next;
    logic [p2t_pkg::COORD_BITS-1:0]   size_reg, size_next;
    logic [p2t_pkg::NORM_BITS-1:0]    q_reg, q_next;
    logic                             zero_reg, zero_next;
    logic [p2t_pkg::CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic                             ge;
    logic [p2t_pkg::COORD_BITS:0]     rem_sub;

    // One compare and subtract per step; offset never exceeds size
    always_comb
    begin
        ge        = rem_reg >= {1'b0, size_reg};
        rem_sub   = ge ? (rem_reg - {1'b0, size_reg}) : rem_reg;
        rem_next  = rem_reg;
        size_next = size_reg;
        q_next    = q_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, off};
            size_next = size;
            q_next    = '0;
            zero_next = (size == '0);
            cnt_next  = p2t_pkg::CNT_BITS'(p2t_pkg::NORM_BITS);
        end
        else if (cnt_reg != '0)
        begin
            q_next    = {q_reg[p2t_pkg::NORM_BITS-2:0], ge};
            rem_next  = {rem_sub[p2t_pkg::COORD_BITS-1:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == p2t_pkg::CNT_BITS'(1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        size_reg <= size_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
    end

    // A zero size gives zero
    assign quo  = zero_reg ? '0 : q_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/pixel_to_tile_lookup_unit.sv
// Top level: tile rectangle table in RAM, row-major scan and two serial dividers.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+------------------------------------
//  s_       | in  | s_tvalid / s_tready       | s_tuser mode, s_tdata load/lookup
//  m_       | out | m_tvalid / m_tready       | m_tuser found, m_tdata tile/norm
//
// A load writes the table entry directly.
// A lookup matching tile k scans the table RAM from entry 0 up to entry k,
// one entry per cycle through its single read port, then runs 17 divider steps.
// A lookup with no match runs the full 64-entry scan.
// Reset clears the sequencer and output valid; the table is not cleared.
// A finished result waits in the output register while the next item is taken.
module pixel_to_tile_lookup_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tile_row, tile_col, rect_x, rect_y, rect_width, rect_height,
    // pixel_x, pixel_y, two zero bits
    input  logic [p2t_pkg::IN_BITS-1:0]    s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tile_number, norm_x, norm_y
    output logic [p2t_pkg::OUT_BITS-1:0]   m_tdata,
    // found
    output logic                           m_tuser
);

    p2t_pkg::state_t                  state_reg, state_next;
    p2t_pkg::in_item_t                in_item;
    p2t_pkg::tile_entry_t             rd_entry;
    p2t_pkg::out_item_t               out_item;

    logic [p2t_pkg::IDX_BITS:0]       addr_reg, addr_next;
    logic                             pend_reg, pend_next;
    logic [p2t_pkg::IDX_BITS-1:0]     idx_reg, idx_next;
    logic [p2t_pkg::COORD_BITS-1:0]   px_reg, px_next;
    logic [p2t_pkg::COORD_BITS-1:0]   py_reg, py_next;
    logic [p2t_pkg::IDX_BITS-1:0]     tile_reg, tile_next;
    logic                             found_reg, found_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             m_found_reg, m_found_next;
    p2t_pkg::out_item_t               m_data_reg, m_data_next;

    logic                             in_xfer;
    logic                             ram_we;
    logic [p2t_pkg::ENTRY_BITS-1:0]   ram_wdata;
    logic [p2t_pkg::ENTRY_BITS-1:0]   ram_rdata;
    logic [p2t_pkg::COORD_BITS:0]     end_x;
    logic [p2t_pkg::COORD_BITS:0]     end_y;
    logic                             hit;
    logic                             div_start;
    logic [p2t_pkg::COORD_BITS-1:0]   off_x;
    logic [p2t_pkg::COORD_BITS-1:0]   off_y;
    logic                             done_x;
    logic                             done_y;
    logic [p2t_pkg::NORM_BITS-1:0]    quo_x;
    logic [p2t_pkg::NORM_BITS-1:0]    quo_y;
    p2t_pkg::tile_entry_t             wr_entry;

    assign in_item  = p2t_pkg::in_item_t'(s_tdata);
    assign s_tready = (state_reg == p2t_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Table write on a load transfer
    always_comb
    begin
        wr_entry.x = in_item.rect_x;
        wr_entry.y = in_item.rect_y;
        wr_entry.w = in_item.rect_width;
        wr_entry.h = in_item.rect_height;
    end

    assign ram_we    = in_xfer && (p2t_pkg::mode_t'(s_tuser) == p2t_pkg::MODE_LOAD);
    assign ram_wdata = wr_entry;

    p2t_ram #(
        .WIDTH (p2t_pkg::ENTRY_BITS),
        .DEPTH (p2t_pkg::TILES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({in_item.tile_row, in_item.tile_col}),
        .wdata (ram_wdata),
        .raddr (addr_reg[p2t_pkg::IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // Inclusive rectangle test on the entry just read
    assign rd_entry = p2t_pkg::tile_entry_t'(ram_rdata);
    assign end_x    = {1'b0, rd_entry.x} + {1'b0, rd_entry.w};
    assign end_y    = {1'b0, rd_entry.y} + {1'b0, rd_entry.h};
    assign hit      = (px_reg >= rd_entry.x) && ({1'b0, px_reg} <= end_x)
                   && (py_reg >= rd_entry.y) && ({1'b0, py_reg} <= end_y);
    assign off_x    = px_reg - rd_entry.x;
    assign off_y    = py_reg - rd_entry.y;
    assign div_start = (state_reg == p2t_pkg::ST_SCAN) && pend_reg && hit;

    p2t_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .off   (off_x),
        .size  (rd_entry.w),
        .done  (done_x),
        .quo   (quo_x)
    );

    p2t_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .off   (off_y),
        .size  (rd_entry.h),
        .done  (done_y),
        .quo   (quo_y)
    );

    // Assemble the result from the dividers, zeros when nothing matched
    always_comb
    begin
        out_item.tile_number = found_reg ? tile_reg : '0;
        out_item.norm_x      = found_reg ? quo_x : '0;
        out_item.norm_y      = found_reg ? quo_y : '0;
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        pend_next    = 1'b0;
        idx_next     = idx_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        tile_next    = tile_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_found_next = m_found_reg;
        m_data_next  = m_data_reg;
        case (state_reg)
            p2t_pkg::ST_IDLE:
            begin
                if (in_xfer && (p2t_pkg::mode_t'(s_tuser) == p2t_pkg::MODE_LOOKUP))
                begin
                    px_next    = in_item.pixel_x;
                    py_next    = in_item.pixel_y;
                    addr_next  = '0;
                    found_next = 1'b0;
                    state_next = p2t_pkg::ST_SCAN;
                end
            end
            p2t_pkg::ST_SCAN:
            begin
                // Issue the next read while entries remain
                if (!addr_reg[p2t_pkg::IDX_BITS])
                begin
                    pend_next = 1'b1;
                    idx_next  = addr_reg[p2t_pkg::IDX_BITS-1:0];
                    addr_next = addr_reg + 1'b1;
                end
                if (pend_reg && hit)
                begin
                    pend_next  = 1'b0;
                    found_next = 1'b1;
                    tile_next  = idx_reg;
                    state_next = p2t_pkg::ST_DIVIDE;
                end
                else if (pend_reg && (idx_reg == p2t_pkg::IDX_BITS'(p2t_pkg::TILES - 1)))
                begin
                    pend_next  = 1'b0;
                    state_next = p2t_pkg::ST_FINISH;
                end
            end
            p2t_pkg::ST_DIVIDE:
            begin
                if (done_x && done_y)
                begin
                    state_next = p2t_pkg::ST_FINISH;
                end
            end
            p2t_pkg::ST_FINISH:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_data_next  = out_item;
                    state_next   = p2t_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = p2t_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= p2t_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        idx_reg     <= idx_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        tile_reg    <= tile_next;
        found_reg   <= found_next;
        m_found_reg <= m_found_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

endmodule
